[hdl/nlb_pkg.sv]
package nlb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LANES         = 4;
    localparam int WEIGHT_W      = 17;
    localparam int SQRT_STEPS    = 32;
    localparam int LERP_LAT      = 3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
    localparam logic [1:0]          FUNC_ROT   = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] a_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] b_w;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               degenerate;
    } t_out;

    typedef struct packed {
        logic                   rot;
        logic                   degen;
        logic [LANES-1:0][31:0] sc;
    } t_side;

endpackage

[hdl/nlb_lerp_lane.sv]
module nlb_lerp_lane (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [31:0]            i_a,
    input  logic signed [31:0]            i_b,
    input  logic [nlb_pkg::WEIGHT_W-1:0]  i_w,
    output logic signed [31:0]            o_c
);

    logic signed [31:0] r_a1;
    logic signed [32:0] r_d1;
    logic signed [31:0] r_a2;
    logic signed [50:0] r_p2;
    logic signed [31:0] r_c3;
    logic signed [50:0] n_p;
    logic signed [50:0] rnd;
    logic signed [35:0] sum;
    logic signed [31:0] n_c;

    always_comb begin
        n_p = r_d1 * $signed({1'b0, i_w});
        rnd = r_p2 + 51'sd32768;
        sum = 36'(r_a2) + 36'(rnd >>> 16);
        if (sum > 36'sd2147483647) begin
            n_c = 32'sh7fff_ffff;
        end else if (sum < -36'sd2147483648) begin
            n_c = 32'sh8000_0000;
        end else begin
            n_c = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1 <= i_a;
            r_d1 <= 33'(i_b) - 33'(i_a);
            r_a2 <= r_a1;
            r_p2 <= n_p;
            r_c3 <= n_c;
        end
    end

    assign o_c = r_c3;

endmodule

[hdl/nlb_isqrt.sv]
module nlb_isqrt (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [63:0]           i_s,
    input  nlb_pkg::t_side        i_side,
    output logic [31:0]           o_root,
    output nlb_pkg::t_side        o_side
);

    localparam int STEPS = nlb_pkg::SQRT_STEPS;

    logic [63:0]    r_x   [STEPS];
    logic [63:0]    r_res [STEPS];
    nlb_pkg::t_side r_side[STEPS];
    logic [63:0]    n_x   [STEPS];
    logic [63:0]    n_res [STEPS];
    nlb_pkg::t_side n_side[STEPS];

    always_comb begin
        logic [63:0] x_in;
        logic [63:0] res_in;
        logic [63:0] bitv;
        logic [63:0] trial;
        for (int j = 0; j < STEPS; j++) begin
            x_in   = (j == 0) ? i_s : r_x[(j == 0) ? 0 : j - 1];
            res_in = (j == 0) ? 64'd0 : r_res[(j == 0) ? 0 : j - 1];
            n_side[j] = (j == 0) ? i_side : r_side[(j == 0) ? 0 : j - 1];
            bitv  = 64'd1 << (2 * (STEPS - 1 - j));
            trial = res_in + bitv;
            if (x_in >= trial) begin
                n_x[j]   = x_in - trial;
                n_res[j] = (res_in >> 1) + bitv;
            end else begin
                n_x[j]   = x_in;
                n_res[j] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_res  <= n_res;
            r_side <= n_side;
        end
    end

    assign o_root = r_res[STEPS-1][31:0];
    assign o_side = r_side[STEPS-1];

endmodule

[hdl/nlb_div_lane.sv]
module nlb_div_lane #(
    parameter int FRAC_BITS = nlb_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [31:0]      i_sc,
    input  logic [31:0]             i_len,
    output logic [FRAC_BITS+1:0]    o_q,
    output logic                    o_neg,
    output logic signed [31:0]      o_val
);

    localparam int QW = FRAC_BITS + 2;
    localparam int NW = FRAC_BITS + 31;

    logic [30:0]        mag;
    logic [NW-1:0]      num;
    logic [31:0]        r_rem0;
    logic [QW-1:0]      r_low0;
    logic [31:0]        r_len0;
    logic               r_neg0;
    logic signed [31:0] r_val0;

    logic [31:0]        r_rem [QW];
    logic [QW-1:0]      r_low [QW];
    logic [QW-1:0]      r_q   [QW];
    logic [31:0]        r_len [QW];
    logic               r_neg [QW];
    logic signed [31:0] r_val [QW];
    logic [31:0]        n_rem [QW];
    logic [QW-1:0]      n_low [QW];
    logic [QW-1:0]      n_q   [QW];
    logic [31:0]        n_len [QW];
    logic               n_neg [QW];
    logic signed [31:0] n_val [QW];

    always_comb begin
        mag = i_sc[31] ? 31'(-i_sc) : 31'(i_sc);
        num = (NW'(mag) << FRAC_BITS) + NW'(i_len >> 1);
    end

    always_comb begin
        logic [31:0]   rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [32:0]   t;
        for (int i = 0; i < QW; i++) begin
            rem_in   = (i == 0) ? r_rem0 : r_rem[(i == 0) ? 0 : i - 1];
            low_in   = (i == 0) ? r_low0 : r_low[(i == 0) ? 0 : i - 1];
            q_in     = (i == 0) ? '0 : r_q[(i == 0) ? 0 : i - 1];
            n_len[i] = (i == 0) ? r_len0 : r_len[(i == 0) ? 0 : i - 1];
            n_neg[i] = (i == 0) ? r_neg0 : r_neg[(i == 0) ? 0 : i - 1];
            n_val[i] = (i == 0) ? r_val0 : r_val[(i == 0) ? 0 : i - 1];
            t = {rem_in, low_in[QW-1]};
            if (t >= {1'b0, n_len[i]}) begin
                n_rem[i] = 32'(t - {1'b0, n_len[i]});
                n_q[i]   = {q_in[QW-2:0], 1'b1};
            end else begin
                n_rem[i] = t[31:0];
                n_q[i]   = {q_in[QW-2:0], 1'b0};
            end
            n_low[i] = low_in << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0 <= 32'(num[NW-1:QW]);
            r_low0 <= num[QW-1:0];
            r_len0 <= i_len;
            r_neg0 <= i_sc[31];
            r_val0 <= i_sc;
            r_rem  <= n_rem;
            r_low  <= n_low;
            r_q    <= n_q;
            r_len  <= n_len;
            r_neg  <= n_neg;
            r_val  <= n_val;
        end
    end

    assign o_q   = r_q[QW-1];
    assign o_neg = r_neg[QW-1];
    assign o_val = r_val[QW-1];

endmodule

[hdl/transform_lerp_nlerp_blend_unit.sv]
// Path: lerp lanes, scaling, sum of squares, square root, dividers, output register (Q16.16 default).
// Throughput: one transaction per cycle unless the output stalls; set by the 32-step
// square-root pipeline and the FRAC_BITS + 2 step divider lanes, all fully pipelined.
// The whole pipeline holds while a result waits under stall.
// Reset (synchronous, active low) clears all valid flags and sets the weight to 0.
module transform_lerp_nlerp_blend_unit #(
    parameter int FRAC_BITS = nlb_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  nlb_pkg::t_in                  i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output nlb_pkg::t_out                 o_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nlb_pkg::WEIGHT_W-1:0]  i_cfg_data
);

    localparam int L       = nlb_pkg::LANES;
    localparam int QW      = FRAC_BITS + 2;
    localparam int DIV_LAT = QW + 1;
    localparam int TOT     = nlb_pkg::LERP_LAT + 7 + nlb_pkg::SQRT_STEPS + DIV_LAT;
    localparam logic [71:0] EPS_SQ =
        72'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000000000);
    localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

    logic                         en;
    logic [nlb_pkg::WEIGHT_W-1:0] r_weight;
    logic [TOT-1:0]               r_vld;
    logic                         r_out_valid;
    nlb_pkg::t_out                r_out;
    nlb_pkg::t_out                n_out;

    logic signed [31:0] a_in [L];
    logic signed [31:0] b_in [L];
    logic signed [31:0] c3   [L];
    logic [nlb_pkg::LERP_LAT-1:0] r_rot_dl;

    logic [31:0]        mag [L];
    logic [31:0]        n_or;
    logic               n_gt;
    logic signed [31:0] r_c4 [L];
    logic [31:0]        r_or4;
    logic               r_gt4, r_rot4;

    logic [4:0]         top_bit;
    logic [4:0]         n_k;
    logic signed [31:0] r_c5 [L];
    logic [4:0]         r_k5;
    logic               r_gt5, r_rot5, r_zero5;

    logic signed [31:0] n_sc [L];
    logic signed [31:0] r_sc6 [L];
    logic [71:0]        r_thr6;
    logic               r_gt6, r_rot6, r_zero6;

    logic signed [63:0] prod [L];
    logic [60:0]        r_sq7 [L];
    logic signed [31:0] r_sc7 [L];
    logic [71:0]        r_thr7;
    logic               r_gt7, r_rot7, r_zero7;

    logic [61:0]        r_ps8 [2];
    logic signed [31:0] r_sc8 [L];
    logic [71:0]        r_thr8;
    logic               r_gt8, r_rot8, r_zero8;

    logic [62:0]        r_s9;
    logic signed [31:0] r_sc9 [L];
    logic [71:0]        r_thr9;
    logic               r_gt9, r_rot9, r_zero9;

    logic [62:0]        r_s10;
    nlb_pkg::t_side     r_side10;

    logic [31:0]        root;
    nlb_pkg::t_side     sq_side;
    logic [QW-1:0]      q   [L];
    logic               neg [L];
    logic signed [31:0] val [L];
    logic signed [31:0] res [L];
    logic [1:0]         r_flag_dl [DIV_LAT];

    assign en          = !r_out_valid || !i_stall;
    assign o_stall     = !en;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        a_in[0] = i_data.a_x;
        a_in[1] = i_data.a_y;
        a_in[2] = i_data.a_z;
        a_in[3] = i_data.a_w;
        b_in[0] = i_data.b_x;
        b_in[1] = i_data.b_y;
        b_in[2] = i_data.b_z;
        b_in[3] = i_data.b_w;
    end

    for (genvar g = 0; g < L; g++) begin : g_lerp
        nlb_lerp_lane u_lerp (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (a_in[g]),
            .i_b   (b_in[g]),
            .i_w   (r_weight),
            .o_c   (c3[g])
        );
    end

    always_comb begin
        n_or = '0;
        n_gt = 1'b0;
        for (int i = 0; i < L; i++) begin
            mag[i] = c3[i][31] ? 32'(-c3[i]) : 32'(c3[i]);
            n_or   = n_or | mag[i];
            n_gt   = n_gt | (mag[i] > 32'h4000_0000);
        end
    end

    always_comb begin
        top_bit = '0;
        for (int i = 0; i < 32; i++) begin
            if (r_or4[i]) begin
                top_bit = 5'(i);
            end
        end
        n_k = (top_bit < 5'd29) ? 5'd29 - top_bit : 5'd0;
    end

    always_comb begin
        for (int i = 0; i < L; i++) begin
            if (!r_rot5) begin
                n_sc[i] = r_c5[i];
            end else if (r_gt5) begin
                n_sc[i] = r_c5[i] >>> 1;
            end else begin
                n_sc[i] = r_c5[i] <<< r_k5;
            end
            prod[i] = r_sc6[i] * r_sc6[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot_dl <= {r_rot_dl[nlb_pkg::LERP_LAT-2:0], i_data.func == nlb_pkg::FUNC_ROT};

            r_c4   <= c3;
            r_or4  <= n_or;
            r_gt4  <= n_gt;
            r_rot4 <= r_rot_dl[nlb_pkg::LERP_LAT-1];

            r_c5    <= r_c4;
            r_k5    <= n_k;
            r_gt5   <= r_gt4;
            r_rot5  <= r_rot4;
            r_zero5 <= (r_or4 == '0);

            r_sc6   <= n_sc;
            r_thr6  <= EPS_SQ << {r_k5, 1'b0};
            r_gt6   <= r_gt5;
            r_rot6  <= r_rot5;
            r_zero6 <= r_zero5;

            for (int i = 0; i < L; i++) begin
                r_sq7[i] <= prod[i][60:0];
            end
            r_sc7   <= r_sc6;
            r_thr7  <= r_thr6;
            r_gt7   <= r_gt6;
            r_rot7  <= r_rot6;
            r_zero7 <= r_zero6;

            r_ps8[0] <= 62'(r_sq7[0]) + 62'(r_sq7[1]);
            r_ps8[1] <= 62'(r_sq7[2]) + 62'(r_sq7[3]);
            r_sc8    <= r_sc7;
            r_thr8   <= r_thr7;
            r_gt8    <= r_gt7;
            r_rot8   <= r_rot7;
            r_zero8  <= r_zero7;

            r_s9    <= 63'(r_ps8[0]) + 63'(r_ps8[1]);
            r_sc9   <= r_sc8;
            r_thr9  <= r_thr8;
            r_gt9   <= r_gt8;
            r_rot9  <= r_rot8;
            r_zero9 <= r_zero8;

            r_s10          <= r_s9;
            r_side10.rot   <= r_rot9;
            r_side10.degen <= r_zero9 || (!r_gt9 && ({9'b0, r_s9} <= r_thr9));
            for (int i = 0; i < L; i++) begin
                r_side10.sc[i] <= r_sc9[i];
            end
        end
    end

    nlb_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_s    ({1'b0, r_s10}),
        .i_side (r_side10),
        .o_root (root),
        .o_side (sq_side)
    );

    for (genvar g = 0; g < L; g++) begin : g_div
        nlb_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_sc  ($signed(sq_side.sc[g])),
            .i_len (root),
            .o_q   (q[g]),
            .o_neg (neg[g]),
            .o_val (val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flag_dl[0] <= {sq_side.rot, sq_side.degen};
            for (int i = 1; i < DIV_LAT; i++) begin
                r_flag_dl[i] <= r_flag_dl[i-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < L; i++) begin
            res[i] = neg[i] ? -$signed(32'(q[i])) : $signed(32'(q[i]));
        end
        n_out = '0;
        if (!r_flag_dl[DIV_LAT-1][1]) begin
            n_out.out_x = val[0];
            n_out.out_y = val[1];
            n_out.out_z = val[2];
        end else if (r_flag_dl[DIV_LAT-1][0]) begin
            n_out.out_w      = Q_ONE;
            n_out.degenerate = 1'b1;
        end else begin
            n_out.out_x = res[0];
            n_out.out_y = res[1];
            n_out.out_z = res[2];
            n_out.out_w = res[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight    <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_weight <= (i_cfg_data > nlb_pkg::WEIGHT_ONE) ? nlb_pkg::WEIGHT_ONE
                                                               : i_cfg_data;
            end
            if (en) begin
                r_vld       <= {r_vld[TOT-2:0], i_valid};
                r_out_valid <= r_vld[TOT-1];
            end
        end
    end

endmodule
